// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/mmr_pkg.sv =====
package mmr_pkg;

    localparam int BUF_DEPTH         = 4096;
    localparam int BUF_AW            = $clog2(BUF_DEPTH);
    localparam int MCTP_HEADER_BYTES = 4;
    localparam int MAX_PACKET_LEN    = 1024;

    localparam int LINK_W   = 8;
    localparam int PLEN_W   = 11;
    localparam int TAG_W    = 3;
    localparam int SEQ_W    = 2;
    localparam int RADDR_W  = 12;
    localparam int TOTAL_W  = 12;
    localparam int IDX_W    = 12;
    localparam int SKIP_W   = 9;
    localparam int FILL_W   = 13;
    localparam int CALC_W   = 18;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_MERGING  = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_SOM_OPEN = 3'd3,
        ST_SEQ_ERR  = 3'd4,
        ST_TAG_ERR  = 3'd5,
        ST_OVERFLOW = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        OUT_NONE   = 2'd0,
        OUT_RESULT = 2'd1,
        OUT_READ   = 2'd2
    } t_out_kind;

    typedef struct packed {
        logic                cmd;
        logic [7:0]          data_byte;
        logic                first_byte;
        logic                start_of_msg;
        logic                end_of_msg;
        logic [TAG_W-1:0]    message_tag;
        logic [SEQ_W-1:0]    packet_seq;
        logic [PLEN_W-1:0]   packet_length;
        logic [LINK_W-1:0]   link_header_len;
        logic [RADDR_W-1:0]  read_addr;
    } t_in_item;

    // One classified item: an optional buffer write and an optional result.
    typedef struct packed {
        logic                wr_en;
        logic [BUF_AW-1:0]   addr;
        logic [7:0]          wr_data;
        t_out_kind           out_kind;
        logic                rd_oob;
        t_status             status;
        logic [FILL_W-1:0]   fill;
        logic [LINK_W-1:0]   offset;
    } t_op;

endpackage

// ===== hw/rtl/mmr_front.sv =====
module mmr_front
    import mmr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_queue_full,
    output logic     o_push,
    output t_op      o_op
);

    logic                r_active, n_active;
    logic                r_store, n_store;
    logic                r_eom, n_eom;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [SKIP_W-1:0]   r_skip, n_skip;
    logic [FILL_W-1:0]   r_base, n_base;
    logic [LINK_W-1:0]   r_link, n_link;
    logic [IDX_W-1:0]    r_idx, n_idx;
    t_status             r_verdict, n_verdict;
    logic                r_ovf, n_ovf;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [TAG_W-1:0]    r_open_tag, n_open_tag;
    logic                r_tag_valid, n_tag_valid;
    logic [SEQ_W-1:0]    r_exp_seq, n_exp_seq;
    logic                r_seq_valid, n_seq_valid;
    t_status             r_last_status, n_last_status;

    logic                accept;
    logic [SEQ_W-1:0]    exp_seq;
    logic [TOTAL_W-1:0]  sum_total;
    logic                do_store;
    logic [CALC_W-1:0]   wr_addr;
    logic                in_range;
    logic                last;
    logic [CALC_W-1:0]   fill_calc;
    t_status             status;
    t_op                 op;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_active      = r_active;
        n_store       = r_store;
        n_eom         = r_eom;
        n_total       = r_total;
        n_skip        = r_skip;
        n_base        = r_base;
        n_link        = r_link;
        n_idx         = r_idx;
        n_verdict     = r_verdict;
        n_ovf         = r_ovf;
        n_fill        = r_fill;
        n_open_tag    = r_open_tag;
        n_tag_valid   = r_tag_valid;
        n_exp_seq     = r_exp_seq;
        n_seq_valid   = r_seq_valid;
        n_last_status = r_last_status;
        exp_seq       = r_seq_valid ? r_exp_seq : '0;
        sum_total     = TOTAL_W'(i_item.link_header_len) + TOTAL_W'(i_item.packet_length);
        do_store      = 1'b0;
        wr_addr       = '0;
        in_range      = 1'b0;
        last          = 1'b0;
        fill_calc     = '0;
        status        = r_verdict;
        op            = '0;
        op.out_kind   = OUT_NONE;
        op.status     = ST_MERGING;

        if (i_item.cmd) begin
            op.out_kind = OUT_READ;
            op.addr     = BUF_AW'(i_item.read_addr);
            op.rd_oob   = CALC_W'(i_item.read_addr) >= CALC_W'(BUF_DEPTH);
            op.status   = r_last_status;
            op.fill     = r_fill;
        end else if (i_item.first_byte || r_active) begin
            if (i_item.first_byte) begin
                // Decide the packet's verdict here, at its first byte.
                n_link    = i_item.link_header_len;
                n_eom     = i_item.end_of_msg;
                n_total   = (sum_total == '0) ? TOTAL_W'(1) : sum_total;
                n_active  = 1'b1;
                n_store   = 1'b0;
                n_skip    = '0;
                n_base    = '0;
                n_idx     = '0;
                n_ovf     = 1'b0;
                if (CALC_W'(i_item.packet_length) < CALC_W'(MCTP_HEADER_BYTES + 1)) begin
                    n_verdict = ST_EMPTY;
                end else if (CALC_W'(i_item.packet_length) > CALC_W'(MAX_PACKET_LEN)) begin
                    n_verdict = ST_OVERFLOW;
                end else if (i_item.start_of_msg) begin
                    n_verdict   = r_tag_valid ? ST_SOM_OPEN : ST_MERGING;
                    n_open_tag  = i_item.message_tag;
                    n_tag_valid = 1'b1;
                    n_exp_seq   = i_item.packet_seq + SEQ_W'(1);
                    n_seq_valid = 1'b1;
                    n_store     = 1'b1;
                end else begin
                    n_exp_seq   = exp_seq + SEQ_W'(1);
                    n_seq_valid = 1'b1;
                    if (exp_seq != i_item.packet_seq) begin
                        n_verdict = ST_SEQ_ERR;
                    end else if (!r_tag_valid || r_open_tag != i_item.message_tag) begin
                        n_verdict = ST_TAG_ERR;
                    end else begin
                        n_verdict = ST_MERGING;
                        n_store   = 1'b1;
                        n_base    = r_fill;
                        n_skip    = SKIP_W'(i_item.link_header_len) + SKIP_W'(MCTP_HEADER_BYTES);
                    end
                end
            end

            // Buffer this byte unless it is skipped or past the end.
            do_store = n_store && (n_idx >= IDX_W'(n_skip));
            wr_addr  = CALC_W'(n_base) + CALC_W'(n_idx) - CALC_W'(n_skip);
            in_range = wr_addr < CALC_W'(BUF_DEPTH);
            if (do_store && !in_range) begin
                n_ovf = 1'b1;
            end
            op.wr_en   = do_store && in_range;
            op.addr    = BUF_AW'(wr_addr);
            op.wr_data = i_item.data_byte;

            last = (CALC_W'(n_idx) + CALC_W'(1)) >= CALC_W'(n_total);
            if (!last) begin
                n_idx = n_idx + IDX_W'(1);
            end else begin
                n_active = 1'b0;
                status   = n_verdict;
                if (n_store) begin
                    fill_calc = CALC_W'(n_base) + CALC_W'(n_total) - CALC_W'(n_skip);
                    n_fill    = (fill_calc > CALC_W'(BUF_DEPTH)) ? FILL_W'(BUF_DEPTH)
                                                                : FILL_W'(fill_calc);
                    if (n_verdict == ST_MERGING && n_ovf) begin
                        status = ST_OVERFLOW;
                    end else if (n_verdict == ST_MERGING && n_eom) begin
                        status    = ST_COMPLETE;
                        op.offset = n_link;
                    end
                end
                op.out_kind = OUT_RESULT;
                op.status   = status;
                op.fill     = n_fill;
                n_last_status = status;
                if (status == ST_COMPLETE) begin
                    n_fill      = '0;
                    n_open_tag  = '0;
                    n_tag_valid = 1'b0;
                    n_exp_seq   = '0;
                    n_seq_valid = 1'b0;
                end
            end
        end
    end

    assign o_push = accept && (op.wr_en || op.out_kind != OUT_NONE);
    assign o_op   = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_store       <= 1'b0;
            r_eom         <= 1'b0;
            r_total       <= '0;
            r_skip        <= '0;
            r_base        <= '0;
            r_link        <= '0;
            r_idx         <= '0;
            r_verdict     <= ST_MERGING;
            r_ovf         <= 1'b0;
            r_fill        <= '0;
            r_open_tag    <= '0;
            r_tag_valid   <= 1'b0;
            r_exp_seq     <= '0;
            r_seq_valid   <= 1'b0;
            r_last_status <= ST_MERGING;
        end else if (accept) begin
            r_active      <= n_active;
            r_store       <= n_store;
            r_eom         <= n_eom;
            r_total       <= n_total;
            r_skip        <= n_skip;
            r_base        <= n_base;
            r_link        <= n_link;
            r_idx         <= n_idx;
            r_verdict     <= n_verdict;
            r_ovf         <= n_ovf;
            r_fill        <= n_fill;
            r_open_tag    <= n_open_tag;
            r_tag_valid   <= n_tag_valid;
            r_exp_seq     <= n_exp_seq;
            r_seq_valid   <= n_seq_valid;
            r_last_status <= n_last_status;
        end
    end

endmodule

// ===== hw/rtl/mmr_queue.sv =====
module mmr_queue
    import mmr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output t_op  o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/mmr_back.sv =====
module mmr_back
    import mmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata
);

    logic [7:0]        r_mem [BUF_DEPTH];
    logic [7:0]        r_rd_data;

    logic              r_s1_valid;
    t_out_kind         r_s1_kind;
    logic              r_s1_oob;
    t_status           r_s1_status;
    logic [FILL_W-1:0] r_s1_fill;
    logic [LINK_W-1:0] r_s1_offset;

    logic              r_out_valid;
    logic [31:0]       r_out_data;

    logic              s1_move;
    logic              s1_free;
    logic              needs_out;
    logic [7:0]        rd_byte;

    assign s1_move   = r_s1_valid && (!r_out_valid || i_m_tready);
    assign s1_free   = !r_s1_valid || s1_move;
    assign needs_out = (i_head.out_kind != OUT_NONE);
    assign o_pop     = !i_empty && (!needs_out || s1_free);
    assign rd_byte   = (r_s1_kind == OUT_READ && !r_s1_oob) ? r_rd_data : 8'd0;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.wr_en) begin
            r_mem[i_head.addr] <= i_head.wr_data;
        end
        if (o_pop && i_head.out_kind == OUT_READ) begin
            r_rd_data <= r_mem[i_head.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && needs_out) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && needs_out) begin
            r_s1_kind   <= i_head.out_kind;
            r_s1_oob    <= i_head.rd_oob;
            r_s1_status <= i_head.status;
            r_s1_fill   <= i_head.fill;
            r_s1_offset <= i_head.offset;
        end
        if (s1_move) begin
            r_out_data <= {rd_byte, r_s1_offset, r_s1_fill, r_s1_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hw/rtl/mctp_message_reassembler.sv =====
// Channel | Dir | Fields (tdata/tuser, lowest bit first)
// s_axis  | in  | tuser: cmd; tdata: data_byte, first_byte, start_of_msg, end_of_msg,
//         |     |   message_tag, packet_seq, packet_length, link_header_len, read_addr, pad
// m_axis  | out | tdata: status, stored_length, message_offset, read_data
//
// One item is taken per cycle while the queue has room; the front decides each byte in the cycle it is taken.
// A result's item is written to a queue slot at the edge that takes it, then passes
// the buffer read stage and the output register before its tvalid rises.
// Reset (synchronous, active low) closes any message and empties the queue at once.
// A stalled output fills the four-entry queue, then holds s_axis tready low.
module mctp_message_reassembler
    import mmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // data_byte, first_byte, start_of_msg, end_of_msg,
                                         // message_tag, packet_seq, packet_length,
                                         // link_header_len, read_addr, one zero bit
    input  logic [0:0]  i_s_axis_tuser,  // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // status, stored_length, message_offset, read_data
);

    t_in_item item;
    t_op      push_op;
    t_op      head_op;
    logic     push;
    logic     pop;
    logic     q_empty;
    logic     q_full;

    assign item.cmd             = i_s_axis_tuser[0];
    assign item.data_byte       = i_s_axis_tdata[7:0];
    assign item.first_byte      = i_s_axis_tdata[8];
    assign item.start_of_msg    = i_s_axis_tdata[9];
    assign item.end_of_msg      = i_s_axis_tdata[10];
    assign item.message_tag     = i_s_axis_tdata[13:11];
    assign item.packet_seq      = i_s_axis_tdata[15:14];
    assign item.packet_length   = i_s_axis_tdata[26:16];
    assign item.link_header_len = i_s_axis_tdata[34:27];
    assign item.read_addr       = i_s_axis_tdata[46:35];

    mmr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_item       (item),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_op         (push_op)
    );

    mmr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mmr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_op),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

// ===== hw/rtl/mmr_checker.sv =====
`include "assert_macros.svh"

module mmr_checker
    import mmr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic [31:0] o_m_axis_tdata
);

    `ASSERT_NEXT_ALWAYS(a_rst_idle, i_clk, !i_rst_n, !o_m_axis_tvalid)

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    `ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[2:0] != 3'd7)

    `ASSERT_IMPL(a_fill_cap, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[15:3] <= FILL_W'(BUF_DEPTH))

    `ASSERT_IMPL(a_offset_on_done, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[2:0] != ST_COMPLETE, o_m_axis_tdata[23:16] == 8'd0)

endmodule

bind mctp_message_reassembler mmr_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
